// File: design/rv32_pkg.sv
// ----------------------------------------------------------------------------
// RV32I execute package
// Shared constants and types for the instruction execute block.
// ----------------------------------------------------------------------------
package rv32_pkg;

    localparam int unsigned DMEM_WORDS = 4096;
    localparam int unsigned DMEM_AW    = $clog2(DMEM_WORDS);

    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_FENCE  = 7'h0F;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [2:0] F3_B  = 3'd0;
    localparam logic [2:0] F3_H  = 3'd1;
    localparam logic [2:0] F3_W  = 3'd2;
    localparam logic [2:0] F3_BU = 3'd4;
    localparam logic [2:0] F3_HU = 3'd5;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        store_done;
        logic        bad_opcode;
    } result_t;

endpackage

// File: design/rv32_if.sv
// ----------------------------------------------------------------------------
// RV32I execute channels
// Valid/ready channels for instructions, results and the start address.
// ----------------------------------------------------------------------------
interface rv32_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;
    modport source (output valid, output instruction, input ready);
    modport sink (input valid, input instruction, output ready);
endinterface

interface rv32_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        store_done;
    logic        bad_opcode;
    modport source (output valid, output next_pc, output reg_write, output reg_index,
                    output reg_value, output store_done, output bad_opcode, input ready);
    modport sink (input valid, input next_pc, input reg_write, input reg_index,
                  input reg_value, input store_done, input bad_opcode, output ready);
endinterface

interface rv32_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/rv32i_instruction_execute_top.sv
// ----------------------------------------------------------------------------
// RV32I instruction execute top level
// Two-stage execute of one RV32I instruction per beat.
// ----------------------------------------------------------------------------
// One instruction is accepted per cycle unless the result channel stalls; its result
// beat passes the stage two registers and the output register before it is presented.
// Stage one decodes, reads the register file and computes the branch target and
// the load/store address, issuing byte-lane reads to the data memory. Stage two
// assembles load data, writes the register file and stores, and presents the
// result beat. Results of stage two are forwarded to stage one; a dependent
// branch or jump still resolves in stage one since the program counter is held
// there, and memory stores are forwarded byte by byte to a following load.
// ----------------------------------------------------------------------------
module rv32i_instruction_execute_top
(
    input  logic clk,
    input  logic rst_n,
    rv32_instr_if.sink    instr,
    rv32_result_if.source result,
    rv32_cfg_if.sink      cfg
);
    import rv32_pkg::*;

    logic [31:0] rf [32];
    logic [31:0] pc_reg;

    // Stage two registers.
    logic        s2_valid_reg;
    result_t     s2_res_reg;
    logic        s2_load_reg;
    logic [2:0]  s2_f3_reg;
    logic [1:0]  s2_lane_reg;
    logic [3:0]  s2_fwd_reg;
    logic [7:0]  s2_fwdb_reg [4];
    logic [DMEM_AW-1:0] s2_waddr_reg [4];
    logic [7:0]  s2_wdata_reg [4];
    logic [3:0]  s2_we_reg;

    // Output skid register.
    logic        out_valid_reg;
    result_t     out_reg;

    logic        s2_go;
    logic        accept;
    logic [7:0]  rdb [4];
    logic [31:0] load_word;
    logic [31:0] load_val;
    result_t     s2_final;

    assign s2_go  = s2_valid_reg && (!out_valid_reg || result.ready);
    assign instr.ready = !s2_valid_reg || s2_go;
    assign accept = instr.valid && instr.ready;
    assign cfg.ready = 1'b1;

    // Stage one decode.
    logic [31:0] ins;
    logic [6:0]  op;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic        b30;
    logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, y, alu, val, npc, ad;
    logic        wr, st, bad, ld, take;
    logic [4:0]  sh;
    logic [31:0] bypass_val;
    logic        bypass_hit_a, bypass_hit_b;

    assign ins = instr.instruction;
    assign op  = ins[6:0];
    assign rd  = ins[11:7];
    assign f3  = ins[14:12];
    assign rs1 = ins[19:15];
    assign rs2 = ins[24:20];
    assign b30 = ins[30];
    assign imm_i = {{20{ins[31]}}, ins[31:20]};
    assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};

    assign bypass_val   = s2_final.reg_value;
    assign bypass_hit_a = s2_valid_reg && s2_final.reg_write && s2_final.reg_index == rs1;
    assign bypass_hit_b = s2_valid_reg && s2_final.reg_write && s2_final.reg_index == rs2;
    assign a = (rs1 == 5'd0) ? 32'd0 : (bypass_hit_a ? bypass_val : rf[rs1]);
    assign b = (rs2 == 5'd0) ? 32'd0 : (bypass_hit_b ? bypass_val : rf[rs2]);
    assign y = (op == OP_REG) ? b : imm_i;
    assign sh = y[4:0];

    always_comb
    begin
        unique case (f3)
            3'd0: alu = (op == OP_REG && b30) ? a - y : a + y;
            3'd1: alu = a << sh;
            3'd2: alu = {31'd0, $signed(a) < $signed(y)};
            3'd3: alu = {31'd0, a < y};
            3'd4: alu = a ^ y;
            3'd5: alu = b30 ? 32'($signed(a) >>> sh) : a >> sh;
            3'd6: alu = a | y;
            default: alu = a & y;
        endcase
    end

    always_comb
    begin
        unique case (f3)
            3'd0: take = a == b;
            3'd1: take = a != b;
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = $signed(a) >= $signed(b);
            3'd6: take = a < b;
            3'd7: take = a >= b;
            default: take = 1'b0;
        endcase
    end

    always_comb
    begin
        npc = pc_reg + 32'd4;
        val = 32'd0;
        wr = 1'b0;
        st = 1'b0;
        bad = 1'b0;
        ld = 1'b0;
        ad = a + imm_i;
        unique case (op)
            OP_REG, OP_IMM:
            begin
                val = alu;
                wr = 1'b1;
            end
            OP_LUI:
            begin
                val = {ins[31:12], 12'd0};
                wr = 1'b1;
            end
            OP_AUIPC:
            begin
                val = {ins[31:12], 12'd0} + pc_reg;
                wr = 1'b1;
            end
            OP_JAL:
            begin
                val = pc_reg + 32'd4;
                npc = pc_reg + imm_j;
                wr = 1'b1;
            end
            OP_JALR:
            begin
                val = pc_reg + 32'd4;
                npc = (a + imm_i) & 32'hFFFF_FFFE;
                wr = 1'b1;
            end
            OP_BRANCH:
            begin
                if (take)
                begin
                    npc = pc_reg + imm_b;
                end
            end
            OP_LOAD:
            begin
                ld = (f3 == F3_B || f3 == F3_H || f3 == F3_W || f3 == F3_BU
                      || f3 == F3_HU);
                wr = ld;
            end
            OP_STORE:
            begin
                ad = a + imm_s;
                st = (f3 == F3_B || f3 == F3_H || f3 == F3_W);
            end
            OP_FENCE, OP_SYSTEM:
            begin
            end
            default:
            begin
                bad = 1'b1;
                npc = pc_reg;
            end
        endcase
        if (rd == 5'd0)
        begin
            wr = 1'b0;
        end
    end

    // Byte lanes of the access: byte k of the access sits at address ad + k.
    logic [31:0]        badr [4];
    logic [DMEM_AW-1:0] lane_addr [4];
    logic [DMEM_AW-1:0] raddr [4];
    logic [DMEM_AW-1:0] st_waddr [4];
    logic [7:0]         st_wdata [4];
    logic [3:0]         st_we;
    logic [3:0]         fwd;
    logic [7:0]         fwdb [4];
    logic [2:0]         nbytes;

    assign nbytes = (f3[1:0] == 2'd0) ? 3'd1 : ((f3[1:0] == 2'd1) ? 3'd2 : 3'd4);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            badr[k] = ad + 32'(k);
            st_waddr[k] = '0;
            st_wdata[k] = '0;
            fwdb[k] = '0;
        end
        st_we = '0;
        // Each physical lane m receives the access byte whose address lands in it.
        for (int m = 0; m < 4; m++)
        begin
            lane_addr[m] = badr[2'(m - int'(ad[1:0]))][DMEM_AW+1:2];
            raddr[m] = lane_addr[m];
        end
        for (int k = 0; k < 4; k++)
        begin
            if (st && accept && 3'(k) < nbytes)
            begin
                st_we[badr[k][1:0]] = 1'b1;
                st_waddr[badr[k][1:0]] = badr[k][DMEM_AW+1:2];
                st_wdata[badr[k][1:0]] = b[8*k +: 8];
            end
        end
        for (int m = 0; m < 4; m++)
        begin
            fwd[m] = s2_valid_reg && s2_we_reg[m] && s2_waddr_reg[m] == lane_addr[m];
            fwdb[m] = s2_wdata_reg[m];
        end
    end

    rv32_dmem u_dmem (
        .clk   (clk),
        .we    (s2_we_reg & {4{s2_valid_reg}}),
        .waddr (s2_waddr_reg),
        .wdata (s2_wdata_reg),
        .re    (accept),
        .raddr (raddr),
        .rdata (rdb)
    );

    // Stage two: assemble load data.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            load_word[8*k +: 8] = s2_fwd_reg[2'(k + int'(s2_lane_reg))]
                ? s2_fwdb_reg[2'(k + int'(s2_lane_reg))]
                : rdb[2'(k + int'(s2_lane_reg))];
        end
        unique case (s2_f3_reg)
            F3_B:    load_val = {{24{load_word[7]}}, load_word[7:0]};
            F3_H:    load_val = {{16{load_word[15]}}, load_word[15:0]};
            F3_BU:   load_val = {24'd0, load_word[7:0]};
            F3_HU:   load_val = {16'd0, load_word[15:0]};
            default: load_val = load_word;
        endcase
        s2_final = s2_res_reg;
        if (s2_load_reg)
        begin
            s2_final.reg_value = load_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
            s2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            s2_we_reg <= '0;
            for (int i = 0; i < 32; i++)
            begin
                rf[i] <= '0;
            end
        end
        else
        begin
            if (cfg.valid)
            begin
                pc_reg <= cfg.data;
            end
            else if (accept)
            begin
                pc_reg <= npc;
            end
            if (s2_go && s2_final.reg_write)
            begin
                rf[s2_final.reg_index] <= s2_final.reg_value;
            end
            if (s2_go)
            begin
                out_valid_reg <= 1'b1;
                out_reg <= s2_final;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                s2_valid_reg <= 1'b1;
                s2_we_reg <= st_we;
            end
            else if (s2_go)
            begin
                s2_valid_reg <= 1'b0;
                s2_we_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_res_reg.next_pc <= npc;
            s2_res_reg.reg_write <= wr;
            s2_res_reg.reg_index <= wr ? rd : 5'd0;
            s2_res_reg.reg_value <= wr ? val : 32'd0;
            s2_res_reg.store_done <= st;
            s2_res_reg.bad_opcode <= bad;
            s2_load_reg <= ld && wr;
            s2_f3_reg <= f3;
            s2_lane_reg <= ad[1:0];
            s2_fwd_reg <= fwd;
            s2_fwdb_reg <= fwdb;
            s2_waddr_reg <= st_waddr;
            s2_wdata_reg <= st_wdata;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.next_pc    = out_reg.next_pc;
    assign result.reg_write  = out_reg.reg_write;
    assign result.reg_index  = out_reg.reg_index;
    assign result.reg_value  = out_reg.reg_value;
    assign result.store_done = out_reg.store_done;
    assign result.bad_opcode = out_reg.bad_opcode;

`ifndef SYNTHESIS
    a_x0_never_written: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.reg_write |-> result.reg_index != 5'd0)
        else $error("write to x0 reported");
    a_bad_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.bad_opcode |-> !result.reg_write && !result.store_done)
        else $error("bad opcode changed state");
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(out_reg))
        else $error("result changed while stalled");
`endif
endmodule

// File: design/rv32_dmem.sv
// ----------------------------------------------------------------------------
// RV32I data memory
// Four byte-lane banks, each with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rv32_dmem
(
    input  logic                         clk,
    input  logic [3:0]                   we,
    input  logic [rv32_pkg::DMEM_AW-1:0] waddr [4],
    input  logic [7:0]                   wdata [4],
    input  logic                         re,
    input  logic [rv32_pkg::DMEM_AW-1:0] raddr [4],
    output logic [7:0]                   rdata [4]
);
    import rv32_pkg::*;

    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        logic [7:0] mem [DMEM_WORDS];
        always_ff @(posedge clk)
        begin
            if (we[g])
            begin
                mem[waddr[g]] <= wdata[g];
            end
            if (re)
            begin
                rdata[g] <= mem[raddr[g]];
            end
        end
    end
endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// RV32I instruction execute testbench
// Sends RV32I instruction words through the instruction channel and checks
// every result beat against a predictor that keeps its own register file,
// program counter and byte-wise data memory. Loads are built only over bytes
// that were stored before. The start address is rewritten between phases.
// ----------------------------------------------------------------------------
import rv32_pkg::*;

class exec_scoreboard;
    localparam int unsigned MEM_BYTES = DMEM_WORDS * 4;

    logic [31:0] regs [32];
    logic [31:0] pc;
    logic [7:0]  mem_b [MEM_BYTES];
    bit          written [MEM_BYTES];
    logic [31:0] stored_at [$];
    result_t     pending [$];
    int          errors;
    int          n_instr, n_loads, n_stores, n_taken, n_bad;

    function new();
        foreach (regs[i]) regs[i] = '0;
        pc = '0;
        errors = 0;
    endfunction

    function void set_pc(logic [31:0] v);
        pc = v;
    endfunction

    function logic [31:0] rd_reg(logic [4:0] i);
        return (i == 0) ? 32'd0 : regs[i];
    endfunction

    function void note_instr(logic [31:0] ins);
        logic [6:0]  op;
        logic [2:0]  f3;
        logic [31:0] a, b, y, imm_i, imm_s, imm_b, imm_j, val, npc, ad, v;
        logic        wr, st, bad, taken;
        int          n;
        result_t     r;
        op = ins[6:0];
        f3 = ins[14:12];
        a = rd_reg(ins[19:15]);
        b = rd_reg(ins[24:20]);
        imm_i = {{20{ins[31]}}, ins[31:20]};
        imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        npc = pc + 32'd4;
        val = '0;
        wr = 0;
        st = 0;
        bad = 0;
        taken = 0;
        n_instr++;
        case (op)
            OP_REG, OP_IMM:
            begin
                y = (op == OP_REG) ? b : imm_i;
                wr = 1;
                case (f3)
                    3'd0: val = (op == OP_REG && ins[30]) ? a - y : a + y;
                    3'd1: val = a << y[4:0];
                    3'd2: val = ($signed(a) < $signed(y)) ? 32'd1 : 32'd0;
                    3'd3: val = (a < y) ? 32'd1 : 32'd0;
                    3'd4: val = a ^ y;
                    3'd5: val = ins[30] ? 32'($signed(a) >>> y[4:0]) : a >> y[4:0];
                    3'd6: val = a | y;
                    default: val = a & y;
                endcase
            end
            OP_LUI:
            begin
                val = {ins[31:12], 12'd0};
                wr = 1;
            end
            OP_AUIPC:
            begin
                val = {ins[31:12], 12'd0} + pc;
                wr = 1;
            end
            OP_JAL:
            begin
                val = pc + 32'd4;
                npc = pc + imm_j;
                wr = 1;
            end
            OP_JALR:
            begin
                val = pc + 32'd4;
                npc = (a + imm_i) & 32'hFFFF_FFFE;
                wr = 1;
            end
            OP_BRANCH:
            begin
                case (f3)
                    3'd0: taken = (a == b);
                    3'd1: taken = (a != b);
                    3'd4: taken = ($signed(a) < $signed(b));
                    3'd5: taken = !($signed(a) < $signed(b));
                    3'd6: taken = (a < b);
                    3'd7: taken = (a >= b);
                    default: taken = 0;
                endcase
                if (taken)
                begin
                    npc = pc + imm_b;
                    n_taken++;
                end
            end
            OP_LOAD:
            begin
                ad = a + imm_i;
                n = (f3 == F3_B || f3 == F3_BU) ? 1 : (f3 == F3_H || f3 == F3_HU) ? 2 : 4;
                v = '0;
                for (int k = 0; k < n; k++)
                    v[8*k +: 8] = mem_b[(ad + k) % MEM_BYTES];
                wr = 1;
                case (f3)
                    F3_B: val = {{24{v[7]}}, v[7:0]};
                    F3_H: val = {{16{v[15]}}, v[15:0]};
                    F3_W, F3_BU, F3_HU: val = v;
                    default: wr = 0;
                endcase
                if (wr)
                    n_loads++;
            end
            OP_STORE:
            begin
                ad = a + imm_s;
                if (f3 <= F3_W)
                begin
                    for (int k = 0; k < (1 << f3); k++)
                    begin
                        mem_b[(ad + k) % MEM_BYTES] = b[8*k +: 8];
                        written[(ad + k) % MEM_BYTES] = 1;
                    end
                    stored_at.push_back(ad);
                    st = 1;
                    n_stores++;
                end
            end
            OP_FENCE, OP_SYSTEM: ;
            default:
            begin
                bad = 1;
                npc = pc;
                n_bad++;
            end
        endcase
        if (wr && ins[11:7] != 0)
        begin
            regs[ins[11:7]] = val;
            r.reg_index = ins[11:7];
        end
        else
        begin
            wr = 0;
            val = '0;
            r.reg_index = '0;
        end
        pc = npc;
        r.next_pc = npc;
        r.reg_write = wr;
        r.reg_value = val;
        r.store_done = st;
        r.bad_opcode = bad;
        pending.push_back(r);
    endfunction

    function void check_result(result_t got);
        result_t want;
        if (pending.size() == 0)
        begin
            $display("%0t: result beat with nothing expected, got %p", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.next_pc !== want.next_pc)
        begin
            $display("%0t: next_pc expected %h actual %h", $time, want.next_pc, got.next_pc);
            errors++;
        end
        if (got.reg_write !== want.reg_write)
        begin
            $display("%0t: reg_write expected %b actual %b", $time, want.reg_write,
                     got.reg_write);
            errors++;
        end
        if (got.reg_index !== want.reg_index)
        begin
            $display("%0t: reg_index expected %0d actual %0d", $time, want.reg_index,
                     got.reg_index);
            errors++;
        end
        if (got.reg_value !== want.reg_value)
        begin
            $display("%0t: reg_value expected %h actual %h", $time, want.reg_value,
                     got.reg_value);
            errors++;
        end
        if (got.store_done !== want.store_done)
        begin
            $display("%0t: store_done expected %b actual %b", $time, want.store_done,
                     got.store_done);
            errors++;
        end
        if (got.bad_opcode !== want.bad_opcode)
        begin
            $display("%0t: bad_opcode expected %b actual %b", $time, want.bad_opcode,
                     got.bad_opcode);
            errors++;
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] OP_UNKNOWN = 7'h7F;
    localparam logic [2:0] F3_MEM_BAD = 3'd3;
    localparam int unsigned MEM_BYTES = DMEM_WORDS * 4;

    typedef enum logic [2:0] {
        ALU_ADD, ALU_SLL, ALU_SLT, ALU_SLTU, ALU_XOR, ALU_SR, ALU_OR, ALU_AND
    } alu_f3_e;

    typedef enum logic [2:0] {
        BR_EQ, BR_NE, BR_BAD2, BR_BAD3, BR_LT, BR_GE, BR_LTU, BR_GEU
    } br_f3_e;

    logic clk;
    logic rst_n;

    rv32_instr_if  instr_ch();
    rv32_result_if res_ch();
    rv32_cfg_if    cfg_ch();

    rv32i_instruction_execute_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    exec_scoreboard sb;
    int burst_left;
    int cfg_writes;

    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd, logic [6:0] op);
        return {imm, rd, op};
    endfunction

    function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
    endfunction

    function automatic bit known_op(logic [6:0] op);
        return op == OP_REG || op == OP_IMM || op == OP_LUI || op == OP_AUIPC ||
               op == OP_JAL || op == OP_JALR || op == OP_BRANCH || op == OP_LOAD ||
               op == OP_STORE || op == OP_FENCE || op == OP_SYSTEM;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("tb: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_result('{res_ch.next_pc, res_ch.reg_write, res_ch.reg_index,
                              res_ch.reg_value, res_ch.store_done, res_ch.bad_opcode});
    end

    // The receiver switches between always ready, coin-flip and mostly stalled.
    initial
    begin
        int mode;
        int left;
        res_ch.ready <= 1'b0;
        left = 0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= 1'($urandom_range(0, 1));
                default: res_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send(logic [31:0] ins);
        instr_ch.valid <= 1'b1;
        instr_ch.instruction <= ins;
        do
            @(posedge clk);
        while (!instr_ch.ready);
        sb.note_instr(ins);
        if (burst_left == 0)
        begin
            instr_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 15);
        end
        else
            burst_left--;
    endtask

    task automatic drain();
        instr_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_start_pc(logic [31:0] v);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.set_pc(v);
        cfg_writes++;
        @(posedge clk);
    endtask

    // Loads a base register so that base plus a signed 12-bit offset hits addr.
    task automatic base_for(logic [31:0] addr, logic [4:0] base, output logic [11:0] lo);
        logic [31:0] hi;
        lo = addr[11:0];
        hi = addr - {{20{lo[11]}}, lo};
        send(enc_u(hi[31:12], base, OP_LUI));
    endtask

    task automatic mem_store();
        logic [31:0] addr;
        logic [11:0] lo;
        logic [4:0]  base;
        logic [4:0]  src;
        addr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MEM_BYTES - 1)
                                           : $urandom_range(0, 255);
        addr = ($urandom() & ~(MEM_BYTES - 1)) | (addr & (MEM_BYTES - 1));
        base = 5'($urandom_range(1, 31));
        src = 5'($urandom_range(0, 31));
        base_for(addr, base, lo);
        send(enc_s(lo, src, base, 3'($urandom_range(0, 2))));
    endtask

    task automatic mem_load();
        logic [31:0] addr;
        logic [31:0] s;
        logic [2:0]  f3;
        logic [11:0] lo;
        logic [4:0]  base;
        bit          ok;
        int          n;
        ok = 0;
        for (int t = 0; t < 20 && !ok; t++)
        begin
            s = sb.stored_at[$urandom_range(0, sb.stored_at.size() - 1)];
            addr = s + $urandom_range(0, 6) - 3;
            case ($urandom_range(0, 4))
                0: f3 = F3_B;
                1: f3 = F3_BU;
                2: f3 = F3_H;
                3: f3 = F3_HU;
                default: f3 = F3_W;
            endcase
            n = (f3 == F3_B || f3 == F3_BU) ? 1 : (f3 == F3_W) ? 4 : 2;
            ok = 1;
            for (int k = 0; k < n; k++)
                if (!sb.written[(addr + k) % MEM_BYTES])
                    ok = 0;
        end
        if (!ok)
        begin
            addr = s;
            f3 = F3_BU;
        end
        addr = ($urandom() & ~(MEM_BYTES - 1)) | (addr & (MEM_BYTES - 1));
        base = 5'($urandom_range(1, 31));
        base_for(addr, base, lo);
        send(enc_i(lo, base, f3, 5'($urandom_range(0, 31)), OP_LOAD));
    endtask

    task automatic random_item();
        int          pick;
        logic [31:0] w;
        pick = $urandom_range(0, 99);
        w = $urandom();
        if (pick < 30)
        begin
            if (pick < 15)
                w[6:0] = OP_REG;
            else
                w[6:0] = OP_IMM;
        end
        else if (pick < 38)
            w[6:0] = (pick < 34) ? OP_LUI : OP_AUIPC;
        else if (pick < 46)
            w[6:0] = OP_BRANCH;
        else if (pick < 51)
            w[6:0] = (pick < 48) ? OP_JAL : OP_JALR;
        else if (pick < 66)
        begin
            mem_store();
            return;
        end
        else if (pick < 83)
        begin
            if (sb.stored_at.size() == 0)
                mem_store();
            else
                mem_load();
            return;
        end
        else if (pick < 87)
            w[6:0] = (pick < 85) ? OP_FENCE : OP_SYSTEM;
        else if (pick < 93)
        begin
            while (known_op(w[6:0]))
                w[6:0] = 7'($urandom());
        end
        if (w[6:0] == OP_LOAD && (w[14:12] <= F3_W || w[14:12] == F3_BU || w[14:12] == F3_HU))
            w[14:12] = F3_MEM_BAD;
        send(w);
    endtask

    task automatic directed();
        send(enc_u(20'h80000, 5'd1, OP_LUI));
        send(enc_i(12'hFFF, 5'd0, ALU_ADD, 5'd2, OP_IMM));
        send(enc_i(12'h7FF, 5'd0, ALU_ADD, 5'd3, OP_IMM));
        send(enc_r(F7_ALT, 5'd2, 5'd0, ALU_ADD, 5'd4, OP_REG));
        send(enc_r(F7_ALT, 5'd2, 5'd1, ALU_SR, 5'd5, OP_REG));
        send(enc_i({F7_ALT, 5'd4}, 5'd1, ALU_SR, 5'd6, OP_IMM));
        send(enc_r(F7_BASE, 5'd2, 5'd1, ALU_SR, 5'd6, OP_REG));
        send(enc_r(F7_BASE, 5'd3, 5'd2, ALU_SLT, 5'd7, OP_REG));
        send(enc_r(F7_BASE, 5'd3, 5'd2, ALU_SLTU, 5'd7, OP_REG));
        send(enc_i(12'h005, 5'd2, ALU_ADD, 5'd0, OP_IMM));
        send(enc_i(12'hFFE, 5'd0, ALU_ADD, 5'd8, OP_IMM));
        // A word store that straddles the top of memory and wraps to address 0.
        send(enc_s(12'h000, 5'd1, 5'd8, F3_W));
        send(enc_i(12'h001, 5'd0, F3_B, 5'd9, OP_LOAD));
        send(enc_i(12'h001, 5'd0, F3_BU, 5'd10, OP_LOAD));
        send(enc_i(12'h000, 5'd0, F3_H, 5'd11, OP_LOAD));
        send(enc_i(12'h000, 5'd0, F3_HU, 5'd12, OP_LOAD));
        send(enc_i(12'hFFE, 5'd0, F3_W, 5'd13, OP_LOAD));
        send(enc_i(12'h000, 5'd0, F3_MEM_BAD, 5'd14, OP_LOAD));
        send(enc_s(12'h010, 5'd2, 5'd0, F3_MEM_BAD));
        send(enc_b(13'h0010, 5'd0, 5'd0, BR_BAD2));
        send(enc_b(13'h1FF8, 5'd0, 5'd0, BR_EQ));
        send(enc_j(21'h1FFFF0, 5'd15));
        send(enc_i(12'h7FF, 5'd3, 3'd0, 5'd16, OP_JALR));
        send(enc_u(20'hFFFFF, 5'd17, OP_AUIPC));
        send(enc_i(12'h000, 5'd0, 3'd0, 5'd0, OP_FENCE));
        send(enc_i(12'h001, 5'd0, 3'd0, 5'd0, OP_SYSTEM));
        send({25'h1FFFFFF, OP_UNKNOWN});
    endtask

    initial
    begin
        sb = new();
        burst_left = 0;
        cfg_writes = 0;
        rst_n <= 1'b0;
        instr_ch.valid <= 1'b0;
        instr_ch.instruction <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed();
        for (int i = 0; i < 190; i++)
            random_item();
        write_start_pc(32'hFFFF_FFFC);
        for (int i = 0; i < 190; i++)
            random_item();
        drain();
        for (int i = 0; i < 190; i++)
            random_item();
        write_start_pc($urandom() & 32'hFFFF_FFFC);
        for (int i = 0; i < 100; i++)
            random_item();
        write_start_pc(32'h0000_0000);
        for (int i = 0; i < 100; i++)
            random_item();
        drain();
        repeat (10) @(posedge clk);
        $display("tb: %0d instructions, %0d loads, %0d stores, %0d taken branches",
                 sb.n_instr, sb.n_loads, sb.n_stores, sb.n_taken);
        $display("tb: %0d unknown opcodes, %0d start address writes", sb.n_bad, cfg_writes);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

// File: filelist.f
design/rv32_pkg.sv
design/rv32_if.sv
design/rv32_dmem.sv
design/rv32i_instruction_execute_top.sv
tb/sv/tb.sv
